>>> rtl/core/rla_pkg.sv
package rla_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  // control from sequencer to the shared shift/subtract unit
  typedef struct packed {
    logic start;
    logic is_mul;
  } unit_ctrl_t;

endpackage

>>> rtl/core/rla_unit.sv
// Shared bit-serial unit: restoring divide (quotient and remainder) or
// shift-add multiply, one bit per cycle.
module rla_unit #(
  parameter int W = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  rla_pkg::unit_ctrl_t ctrl,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic               done,
  output logic [W-1:0]       quo,
  output logic [W-1:0]       rem,
  output logic [2*W-1:0]     prod
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0]  cnt;
  logic           busy;
  logic           is_mul;
  logic [W-1:0]   dvs;
  logic [W-1:0]   q;
  logic [W:0]     r;
  logic [2*W-1:0] acc;
  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [W:0]     r_sh;
  logic           fits;

  assign r_sh = {r[W-1:0], q[W-1]};
  assign fits = r_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy   <= 1'b1;
        is_mul <= ctrl.is_mul;
        cnt    <= CW'(W);
        dvs    <= b;
        q      <= a;
        r      <= '0;
        acc    <= '0;
        mcand  <= {{W{1'b0}}, a};
        mplier <= b;
      end else if (busy) begin
        if (is_mul) begin
          if (mplier[0]) acc <= acc + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end else begin
          r <= fits ? r_sh - {1'b0, dvs} : r_sh;
          q <= {q[W-2:0], fits};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo  = q;
  assign rem  = r[W-1:0];
  assign prod = acc;

endmodule

>>> rtl/core/rla_seq.sv
// Sequencer: Euclid via repeated remainders, then v/g, then q*acc.
module rla_seq #(
  parameter int W = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [W-1:0]        v_in,
  input  logic                first_in,
  input  logic                last_in,
  input  logic                out_ready,
  output logic                busy,
  output logic                out_valid,
  output logic [W-1:0]        acc_o,
  output logic                ovf_o,
  output logic                last_o,
  output rla_pkg::unit_ctrl_t ctrl,
  output logic [W-1:0]        ua,
  output logic [W-1:0]        ub,
  input  logic                udone,
  input  logic [W-1:0]        uquo,
  input  logic [W-1:0]        urem,
  input  logic [2*W-1:0]      uprod
);

  rla_pkg::state_t state, state_next;
  logic [W-1:0] acc, v, x, y, g;
  logic         ovf, last, pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rla_pkg::ST_IDLE;
      acc   <= '0;
      ovf   <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= 1'b0;
      unique case (state)
        rla_pkg::ST_IDLE: begin
          if (in_fire) begin
            last <= last_in;
            v    <= v_in;
            x    <= v_in;
            y    <= acc;
            if (first_in) begin
              acc <= v_in;
              ovf <= 1'b0;
            end else if (acc == '0) begin
              acc <= '0;
            end else begin
              pend <= 1'b1;
            end
          end
        end
        rla_pkg::ST_GCD: begin
          if (udone) begin
            x <= y;
            y <= urem;
            if (urem == '0) begin
              g    <= y;
              pend <= 1'b1;
            end else begin
              pend <= 1'b1;
            end
          end
        end
        rla_pkg::ST_DIV: begin
          if (udone) begin
            v    <= uquo;
            pend <= 1'b1;
          end
        end
        rla_pkg::ST_MUL: begin
          if (udone) begin
            if (uprod[2*W-1:W] != '0) begin
              acc <= '1;
              ovf <= 1'b1;
            end else begin
              acc <= uprod[W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // a zero accumulator makes the lcm zero (both-zero case too)
  always_comb begin
    state_next  = state;
    ctrl.start  = pend;
    ctrl.is_mul = 1'b0;
    ua = x;
    ub = y;
    unique case (state)
      rla_pkg::ST_IDLE:
        if (in_fire) state_next = (!first_in && acc != '0) ? rla_pkg::ST_GCD
                                                            : rla_pkg::ST_OUT;
      rla_pkg::ST_GCD:
        if (udone && urem == '0) state_next = rla_pkg::ST_DIV;
      rla_pkg::ST_DIV: begin
        ua = v;
        ub = g;
        if (udone) state_next = rla_pkg::ST_MUL;
      end
      rla_pkg::ST_MUL: begin
        ua = v;
        ub = acc;
        ctrl.is_mul = 1'b1;
        if (udone) state_next = rla_pkg::ST_OUT;
      end
      rla_pkg::ST_OUT:
        if (out_ready) state_next = rla_pkg::ST_IDLE;
      default: state_next = rla_pkg::ST_IDLE;
    endcase
  end

  assign busy      = state != rla_pkg::ST_IDLE;
  assign out_valid = state == rla_pkg::ST_OUT;
  assign acc_o     = acc;
  assign ovf_o     = ovf;
  assign last_o    = last;

endmodule

>>> rtl/core/running_lcm_accumulator.sv
// Running lcm over sets of integers. Each request yields one result: the
// lcm of the set so far (saturated to all ones on overflow), a sticky
// overflow flag cleared by first_item, and set_done echoing last_item.
// A first item or a zero accumulator goes from idle straight to the
// output state. Otherwise one shared bit-serial divide/multiply unit
// does the work in passes: one per Euclid remainder (up to
// ~1.44*VALUE_BITS passes), one for value/gcd, one multiply.
// The block takes one request at a time; in_ready is low while busy.
// Bits of value above VALUE_BITS are ignored.
module running_lcm_accumulator #(
  parameter int VALUE_BITS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [62:0] value,
  input  logic        first_item,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [62:0] running_lcm,
  output logic        overflow,
  output logic        set_done
);

  localparam int W = VALUE_BITS;

  logic                busy;
  logic                in_fire;
  rla_pkg::unit_ctrl_t ctrl;
  logic [W-1:0]        ua, ub, uquo, urem, acc;
  logic [2*W-1:0]      uprod;
  logic                udone;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  rla_seq #(.W(W)) u_seq (
    .clk(clk), .rst(rst), .in_fire(in_fire), .v_in(value[W-1:0]),
    .first_in(first_item), .last_in(last_item), .out_ready(out_ready),
    .busy(busy), .out_valid(out_valid), .acc_o(acc), .ovf_o(overflow),
    .last_o(set_done), .ctrl(ctrl), .ua(ua), .ub(ub), .udone(udone),
    .uquo(uquo), .urem(urem), .uprod(uprod)
  );

  rla_unit #(.W(W)) u_unit (
    .clk(clk), .rst(rst), .ctrl(ctrl), .a(ua), .b(ub), .done(udone),
    .quo(uquo), .rem(urem), .prod(uprod)
  );

  assign running_lcm = 63'(acc);

endmodule

>>> rtl/core/rla_checker.sv
module rla_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overflow,
  input logic set_done
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(overflow)
      && $stable(set_done)) else $error("result dropped");

endmodule

bind running_lcm_accumulator rla_checker u_rla_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .overflow(overflow),
  .set_done(set_done)
);
